// ===== sv/btt_pkg.sv =====
// package for the tracker beacon table: sizes, codes, entry type, fsm states
// used by the top level of the block; depends on nothing

package btt_pkg;

   localparam int MaxEntries   = 16;
   localparam int IdxW         = 4;
   localparam int CntW         = 5;
   localparam int PayloadBytes = 8;

   localparam logic [15:0] IdKind1 = 16'h004C;
   localparam logic [15:0] IdKind2 = 16'h0075;
   localparam logic [15:0] IdKind3 = 16'h0059;
   localparam logic [31:0] TimeoutReset = 32'd30000;

   typedef enum logic [1:0] {
      ACT_OBSERVE = 2'd0,
      ACT_SWEEP   = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_READ    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_IGNORED  = 3'd2,
      ST_FULL     = 3'd3,
      ST_DONE     = 3'd4,
      ST_BADIDX   = 3'd5
   } status_type;

   typedef struct packed {
      logic [47:0] addr;
      logic [7:0]  adv_type;
      logic [7:0]  rssi;
      logic [1:0]  kind;
      logic [31:0] seen;
      logic [63:0] payload;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_MATCH,
      FSM_SWEEP,
      FSM_READ,
      FSM_RESP
   } fsm_type;

   // tracker kind from the little-endian manufacturer id
   function automatic logic [1:0] kind_of(input logic [63:0] bytes, input logic [7:0] len);
      logic [1:0] k;
      k = 2'd0;
      if (len >= 8'd2) begin
         if (bytes[15:0] == IdKind1) k = 2'd1;
         else if (bytes[15:0] == IdKind2) k = 2'd2;
         else if (bytes[15:0] == IdKind3) k = 2'd3;
      end
      return k;
   endfunction

   // keep only the first len bytes
   function automatic logic [63:0] trim_payload(input logic [63:0] bytes, input logic [7:0] len);
      logic [63:0] p;
      for (int b = 0; b < PayloadBytes; b++) begin
         p[8*b +: 8] = (len > 8'(b)) ? bytes[8*b +: 8] : 8'd0;
      end
      return p;
   endfunction

endpackage

// ===== sv/btt_ram.sv =====
// generic single-port-write, single-read ram with registered read data
// no dependencies

module btt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== sv/ble_tracker_table_with_aging.sv =====
// top level of the tracker beacon table: control sequencer around one entry ram
// depends on btt_pkg and btt_ram

// One word is taken when start is high and busy low; its result is given
// with rsp_valid high for one cycle and cannot be stalled. Observe and sweep
// walk the table through the single entry ram with one read in flight at a
// time, so each entry visited is read before the next read is issued; read
// fetches one entry and clear touches no entry. No new word is taken while
// an item is in progress; the next word can be taken in the cycle after the
// result. The count of valid entries lives in a register; the ram needs no
// clearing after reset.
module ble_tracker_table_with_aging (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [47:0] req_dev_addr,
   input  logic [7:0]  req_dev_addr_type,
   input  logic signed [7:0] req_signal_rssi,
   input  logic [7:0]  req_mfg_length,
   input  logic [63:0] req_mfg_bytes,
   input  logic [31:0] req_now_ms,
   input  logic [3:0]  req_entry_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_age_timeout_ms,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_entry_count,
   output logic [47:0] rsp_out_addr,
   output logic [7:0]  rsp_out_addr_type,
   output logic signed [7:0] rsp_out_rssi,
   output logic [1:0]  rsp_out_kind,
   output logic [31:0] rsp_out_last_seen,
   output logic [63:0] rsp_out_payload
);

   btt_pkg::fsm_type state_ff, state_in;
   logic [31:0] timeout_ff;
   logic [btt_pkg::CntW-1:0] count_ff, count_in;
   logic [btt_pkg::CntW-1:0] rd_ptr_ff, rd_ptr_in;   // next entry to read
   logic [btt_pkg::CntW-1:0] wr_ptr_ff, wr_ptr_in;   // compaction write slot
   logic                     pend_ff, pend_in;       // read data valid this cycle
   logic [btt_pkg::IdxW-1:0] pend_idx_ff, pend_idx_in;

   // captured request
   logic [1:0]  act_ff;
   logic [47:0] addr_ff;
   logic [7:0]  atype_ff, rssi_ff, len_ff;
   logic [63:0] bytes_ff;
   logic [31:0] now_ff;
   logic [3:0]  idx_ff;

   // result register
   logic [2:0]          st_ff, st_in;
   btt_pkg::entry_type  res_ff, res_in;
   logic                rv_ff;

   logic                     we;
   logic [btt_pkg::IdxW-1:0] wa, ra;
   btt_pkg::entry_type       wd, rd;
   logic [btt_pkg::EntryW-1:0] rd_bits;

   btt_ram #(.Width(btt_pkg::EntryW), .Depth(btt_pkg::MaxEntries)) u_ram (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr(wa),
      .wr_data(wd),
      .rd_addr(ra),
      .rd_data(rd_bits)
   );
   assign rd = btt_pkg::entry_type'(rd_bits);

   logic accept;
   assign accept    = start && !busy;
   assign busy      = (state_ff != btt_pkg::FSM_IDLE);
   assign csr_ready = 1'b1;

   logic [31:0] age;
   logic        keep;
   logic [1:0]  kind;
   logic        last_read;
   assign age       = now_ff - rd.seen;
   assign keep      = !(age > timeout_ff);
   assign kind      = btt_pkg::kind_of(bytes_ff, len_ff);
   assign ra        = rd_ptr_ff[btt_pkg::IdxW-1:0];
   assign last_read = (rd_ptr_ff >= count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         btt_pkg::FSM_IDLE: begin
            if (accept) begin
               unique case (btt_pkg::action_type'(req_action))
                  btt_pkg::ACT_OBSERVE: state_in = btt_pkg::FSM_MATCH;
                  btt_pkg::ACT_SWEEP:   state_in = btt_pkg::FSM_SWEEP;
                  btt_pkg::ACT_CLEAR:   state_in = btt_pkg::FSM_RESP;
                  btt_pkg::ACT_READ:    state_in = btt_pkg::FSM_READ;
               endcase
            end
         end
         btt_pkg::FSM_MATCH: begin
            if (kind == 2'd0) state_in = btt_pkg::FSM_RESP;
            else if (pend_ff && rd.addr == addr_ff) state_in = btt_pkg::FSM_RESP;
            else if (!pend_ff && last_read) state_in = btt_pkg::FSM_RESP;
         end
         btt_pkg::FSM_SWEEP: begin
            if (!pend_ff && last_read) state_in = btt_pkg::FSM_RESP;
         end
         btt_pkg::FSM_READ: begin
            if (pend_ff || !({1'b0, idx_ff} < count_ff))
               state_in = btt_pkg::FSM_RESP;
         end
         btt_pkg::FSM_RESP: state_in = btt_pkg::FSM_IDLE;
         default: state_in = btt_pkg::FSM_IDLE;
      endcase
   end

   // datapath and outputs of the sequencer
   always_comb begin
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      pend_in     = 1'b0;
      pend_idx_in = ra;
      st_in       = st_ff;
      res_in      = res_ff;
      we          = 1'b0;
      wa          = pend_idx_ff;
      wd          = rd;
      unique case (state_ff)
         btt_pkg::FSM_IDLE: begin
            rd_ptr_in = '0;
            wr_ptr_in = '0;
            res_in    = '0;
            if (accept && btt_pkg::action_type'(req_action) == btt_pkg::ACT_CLEAR) begin
               count_in = '0;
               st_in    = btt_pkg::ST_DONE;
            end else if (accept && btt_pkg::action_type'(req_action) == btt_pkg::ACT_READ) begin
               // point the first read at the requested entry
               rd_ptr_in = {1'b0, req_entry_index};
            end
         end
         btt_pkg::FSM_MATCH: begin
            if (kind == 2'd0) begin
               st_in  = btt_pkg::ST_IGNORED;
               res_in = '0;
            end else if (pend_ff && rd.addr == addr_ff) begin
               wd      = rd;
               wd.rssi = rssi_ff;
               wd.seen = now_ff;
               we      = 1'b1;
               st_in   = btt_pkg::ST_UPDATED;
               res_in  = wd;
            end else if (!pend_ff && last_read) begin
               if (count_ff >= btt_pkg::CntW'(btt_pkg::MaxEntries)) begin
                  st_in  = btt_pkg::ST_FULL;
                  res_in = '0;
               end else begin
                  wd.addr      = addr_ff;
                  wd.adv_type  = atype_ff;
                  wd.rssi      = rssi_ff;
                  wd.kind      = kind;
                  wd.seen      = now_ff;
                  wd.payload   = btt_pkg::trim_payload(bytes_ff, len_ff);
                  wa           = count_ff[btt_pkg::IdxW-1:0];
                  we           = 1'b1;
                  count_in     = count_ff + 1'b1;
                  st_in        = btt_pkg::ST_INSERTED;
                  res_in       = wd;
               end
            end else if (!pend_ff) begin
               // one read in flight at a time keeps match and update ordered
               pend_in   = 1'b1;
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
         end
         btt_pkg::FSM_SWEEP: begin
            if (pend_ff && keep) begin
               we        = 1'b1;
               wa        = wr_ptr_ff[btt_pkg::IdxW-1:0];
               wr_ptr_in = wr_ptr_ff + 1'b1;
            end
            if (!pend_ff && last_read) begin
               count_in = wr_ptr_ff;
               st_in    = btt_pkg::ST_DONE;
               res_in   = '0;
            end else if (!pend_ff) begin
               pend_in   = 1'b1;
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
         end
         btt_pkg::FSM_READ: begin
            rd_ptr_in = {1'b0, idx_ff};
            if (!({1'b0, idx_ff} < count_ff)) begin
               st_in  = btt_pkg::ST_BADIDX;
               res_in = '0;
            end else if (pend_ff) begin
               st_in  = btt_pkg::ST_DONE;
               res_in = rd;
            end else begin
               pend_in = 1'b1;
            end
         end
         btt_pkg::FSM_RESP: ;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= btt_pkg::FSM_IDLE;
         count_ff   <= '0;
         timeout_ff <= btt_pkg::TimeoutReset;
         pend_ff    <= 1'b0;
         rv_ff      <= 1'b0;
         rd_ptr_ff  <= '0;
         wr_ptr_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         rv_ff     <= (state_in == btt_pkg::FSM_RESP) && (state_ff != btt_pkg::FSM_RESP);
         if (csr_valid && csr_ready) timeout_ff <= csr_age_timeout_ms;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      st_ff       <= st_in;
      res_ff      <= res_in;
      if (accept) begin
         act_ff   <= req_action;
         addr_ff  <= req_dev_addr;
         atype_ff <= req_dev_addr_type;
         rssi_ff  <= req_signal_rssi;
         len_ff   <= req_mfg_length;
         bytes_ff <= req_mfg_bytes;
         now_ff   <= req_now_ms;
         idx_ff   <= req_entry_index;
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_status        = st_ff;
   assign rsp_entry_count   = count_ff;
   assign rsp_out_addr      = res_ff.addr;
   assign rsp_out_addr_type = res_ff.adv_type;
   assign rsp_out_rssi      = res_ff.rssi;
   assign rsp_out_kind      = res_ff.kind;
   assign rsp_out_last_seen = res_ff.seen;
   assign rsp_out_payload   = res_ff.payload;

   // table never exceeds its depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= btt_pkg::CntW'(btt_pkg::MaxEntries))
      else $error("entry count above table depth");

   // a result is only given while an item is in progress
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result without an item");

   // compaction never overtakes the read pointer
   a_compact: assert property (@(posedge clock) disable iff (reset)
      state_ff == btt_pkg::FSM_SWEEP |-> wr_ptr_ff <= rd_ptr_ff)
      else $error("compaction write ahead of read");

   // sweep never grows the table
   a_sweep_shrinks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && act_ff == btt_pkg::ACT_SWEEP) |->
         count_ff <= $past(count_ff, 2) || $past(reset, 2))
      else $error("sweep grew the table");

endmodule
